// ===== src/lat_pkg.sv =====
// Shared types, constants and helpers for the looping animation timer.
`timescale 1ns / 1ps

package lat_pkg;

   localparam int TIME_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int DELTA_WIDTH = 20;
   localparam int RATE_WIDTH  = 16;
   localparam int RATE_FRAC   = 8;
   localparam int PROD_WIDTH  = DELTA_WIDTH + 1 + RATE_WIDTH;
   localparam int INC_WIDTH   = PROD_WIDTH - RATE_FRAC;
   localparam int SUM_WIDTH   = TIME_WIDTH + 2;
   localparam int DUR_WIDTH   = TIME_WIDTH - 1;
   localparam int DIV_STEPS   = TIME_WIDTH;
   localparam int CNT_WIDTH   = $clog2(DIV_STEPS);
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DURATION_FINITE = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DURATION        = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_LOOPED          = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RATE            = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_OFFSET          = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SHARED_TIME     = 3'd5;

   localparam logic [DUR_WIDTH-1:0] DURATION_RESET = DUR_WIDTH'(1) << FRAC_BITS;
   localparam logic signed [RATE_WIDTH-1:0] RATE_RESET = RATE_WIDTH'(1) << RATE_FRAC;

   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {3'b000, {(TIME_WIDTH-1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {3'b111, {(TIME_WIDTH-1){1'b0}}};

   typedef struct packed {
      logic                           op;
      logic [DELTA_WIDTH-1:0]         delta_time;
      logic signed [TIME_WIDTH-1:0]   time_value;
   } req_type;

   typedef struct packed {
      logic signed [TIME_WIDTH-1:0]   eval_time;
      logic                           action_fired;
      logic                           is_stopped;
      logic signed [TIME_WIDTH-1:0]   time_now;
   } rsp_type;

   typedef struct packed {
      logic                           duration_finite;
      logic [DUR_WIDTH-1:0]           duration;
      logic                           looped;
      logic signed [RATE_WIDTH-1:0]   rate;
      logic signed [TIME_WIDTH-1:0]   offset;
      logic                           shared_time;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic prep;
      logic mul;
      logic adv;
      logic eval;
      logic check;
      logic div_step;
      logic wrap;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic need_div;
   } status_type;

   function automatic logic signed [TIME_WIDTH-1:0] sat_time(
      input logic signed [SUM_WIDTH-1:0] v
   );
      logic signed [SUM_WIDTH-1:0] r;
      r = v;
      if (v > SUM_MAX) begin
         r = SUM_MAX;
      end else if (v < SUM_MIN) begin
         r = SUM_MIN;
      end
      return r[TIME_WIDTH-1:0];
   endfunction

endpackage

// ===== src/lat_datapath.sv =====
// Datapath: running time, stopped flag, rate multiply, sums and serial modulo.
`timescale 1ns / 1ps

module lat_datapath import lat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_data
);

   logic                          op_ff, op_in;
   logic [DELTA_WIDTH-1:0]        delta_ff, delta_in;
   logic signed [TIME_WIDTH-1:0]  tval_ff, tval_in;
   logic signed [TIME_WIDTH-1:0]  run_time_ff, run_time_in;
   logic                          stopped_ff, stopped_in;
   logic signed [PROD_WIDTH-1:0]  prod_ff, prod_in;
   logic signed [TIME_WIDTH-1:0]  eval_ff, eval_in;
   logic                          fired_ff, fired_in;
   logic [TIME_WIDTH-1:0]         rem_ff, rem_in;
   logic [TIME_WIDTH-1:0]         quo_ff, quo_in;
   rsp_type                       rsp_ff, rsp_in;

   logic [DUR_WIDTH-1:0]          dur_eff;
   logic signed [TIME_WIDTH:0]    dur_cmp;
   logic signed [TIME_WIDTH-1:0]  rt_sel;
   logic                          rt_below;
   logic                          eval_above;
   logic signed [INC_WIDTH-1:0]   inc;
   logic signed [SUM_WIDTH-1:0]   sum_adv, sum_eval, sum_wrap;
   logic [TIME_WIDTH-1:0]         trial;

   assign dur_eff    = (cfg.duration == '0) ? DUR_WIDTH'(1) : cfg.duration;
   assign dur_cmp    = $signed({2'b00, dur_eff});
   assign rt_sel     = op_ff ? tval_ff : run_time_ff;
   assign rt_below   = $signed({rt_sel[TIME_WIDTH-1], rt_sel}) < dur_cmp;
   assign eval_above = $signed({eval_ff[TIME_WIDTH-1], eval_ff}) > dur_cmp;
   assign inc        = prod_ff[PROD_WIDTH-1:RATE_FRAC];
   assign sum_adv    = SUM_WIDTH'(run_time_ff) + SUM_WIDTH'(inc);
   assign sum_eval   = SUM_WIDTH'(run_time_ff) + SUM_WIDTH'(cfg.offset);
   assign sum_wrap   = $signed({2'b00, rem_ff}) - SUM_WIDTH'(cfg.offset);
   assign trial      = {rem_ff[TIME_WIDTH-2:0], quo_ff[TIME_WIDTH-1]};

   assign status.need_div = cfg.duration_finite && !stopped_ff && eval_above && cfg.looped;
   assign rsp_data = rsp_ff;

   always_comb begin
      op_in       = op_ff;
      delta_in    = delta_ff;
      tval_in     = tval_ff;
      run_time_in = run_time_ff;
      stopped_in  = stopped_ff;
      prod_in     = prod_ff;
      eval_in     = eval_ff;
      fired_in    = fired_ff;
      rem_in      = rem_ff;
      quo_in      = quo_ff;
      rsp_in      = rsp_ff;
      if (cmd.capture) begin
         op_in    = req_data.op;
         delta_in = req_data.delta_time;
         tval_in  = req_data.time_value;
      end
      if (cmd.prep) begin
         run_time_in = rt_sel;
         if (cfg.shared_time && (!cfg.duration_finite || rt_below)) begin
            stopped_in = 1'b0;
         end
      end
      if (cmd.mul) begin
         prod_in = $signed({1'b0, delta_ff}) * cfg.rate;
      end
      if (cmd.adv && !stopped_ff) begin
         run_time_in = sat_time(sum_adv);
      end
      if (cmd.eval) begin
         eval_in = sat_time(sum_eval);
      end
      if (cmd.check) begin
         fired_in = cfg.duration_finite && !stopped_ff && eval_above;
         if (cfg.duration_finite && !stopped_ff && eval_above && !cfg.looped) begin
            stopped_in = 1'b1;
         end
         rem_in = '0;
         quo_in = eval_ff;
      end
      if (cmd.div_step) begin
         rem_in = (trial >= {1'b0, dur_eff}) ? trial - {1'b0, dur_eff} : trial;
         quo_in = {quo_ff[TIME_WIDTH-2:0], 1'b0};
      end
      if (cmd.wrap) begin
         eval_in     = rem_ff;
         run_time_in = sat_time(sum_wrap);
      end
      if (cmd.finish) begin
         rsp_in.eval_time    = (stopped_ff && cfg.duration_finite && eval_above) ?
                               TIME_WIDTH'(dur_eff) : eval_ff;
         rsp_in.action_fired = fired_ff;
         rsp_in.is_stopped   = stopped_ff;
         rsp_in.time_now     = run_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_time_ff <= '0;
         stopped_ff  <= 1'b0;
      end else begin
         run_time_ff <= run_time_in;
         stopped_ff  <= stopped_in;
      end
      op_ff    <= op_in;
      delta_ff <= delta_in;
      tval_ff  <= tval_in;
      prod_ff  <= prod_in;
      eval_ff  <= eval_in;
      fired_ff <= fired_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      rsp_ff   <= rsp_in;
   end

endmodule

// ===== src/lat_ctrl.sv =====
// Controller: sequences one tick through the datapath and owns the handshakes.
`timescale 1ns / 1ps

module lat_ctrl import lat_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_PREP,
      S_MUL,
      S_ADV,
      S_EVAL,
      S_CHECK,
      S_DIV,
      S_WRAP,
      S_FINISH
   } state_type;

   state_type              state_ff;
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic                   rsp_valid_ff;
   logic                   finish_go;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign finish_go = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      cmd          = '0;
      cmd.capture  = req_valid && (state_ff == S_IDLE);
      cmd.prep     = (state_ff == S_PREP);
      cmd.mul      = (state_ff == S_MUL);
      cmd.adv      = (state_ff == S_ADV);
      cmd.eval     = (state_ff == S_EVAL);
      cmd.check    = (state_ff == S_CHECK);
      cmd.div_step = (state_ff == S_DIV);
      cmd.wrap     = (state_ff == S_WRAP);
      cmd.finish   = finish_go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= finish_go || (rsp_valid_ff && rsp_stall);
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP:  state_ff <= S_MUL;
            S_MUL:   state_ff <= S_ADV;
            S_ADV:   state_ff <= S_EVAL;
            S_EVAL:  state_ff <= S_CHECK;
            S_CHECK: begin
               cnt_ff <= '0;
               state_ff <= status.need_div ? S_DIV : S_FINISH;
            end
            S_DIV: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1)) begin
                  state_ff <= S_WRAP;
               end
            end
            S_WRAP:  state_ff <= S_FINISH;
            S_FINISH: begin
               if (finish_go) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== src/looping_animation_timer_top.sv =====
// Top level of the looping animation timer: register file, controller and datapath.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_stall  req_data (op, delta_time, time_value)
//   rsp_     out        rsp_valid/rsp_stall  rsp_data (eval_time, action_fired, ...)
//   csr_     in         csr_valid/csr_ready  csr_index, csr_wdata
//
// A request passes prep, multiply, advance, eval, check and finish; when a looped timer
// wraps, the modulo runs one quotient bit per cycle, then a wrap step, in the datapath.
// One request is in work at a time; the next is taken while the last result waits.
// Synchronous active-high reset clears the running time and stopped flag and sets the CSRs to defaults.
// A stalled result holds its register and the tick waits in its final state.
`timescale 1ns / 1ps

module looping_animation_timer_top import lat_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [TIME_WIDTH-1:0]     csr_wdata
);

   cfg_type    cfg_ff;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.duration_finite <= 1'b0;
         cfg_ff.duration        <= DURATION_RESET;
         cfg_ff.looped          <= 1'b1;
         cfg_ff.rate            <= RATE_RESET;
         cfg_ff.offset          <= '0;
         cfg_ff.shared_time     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_DURATION_FINITE: cfg_ff.duration_finite <= csr_wdata[0];
            CSR_DURATION:        cfg_ff.duration        <= csr_wdata[DUR_WIDTH-1:0];
            CSR_LOOPED:          cfg_ff.looped          <= csr_wdata[0];
            CSR_RATE:            cfg_ff.rate            <= csr_wdata[RATE_WIDTH-1:0];
            CSR_OFFSET:          cfg_ff.offset          <= csr_wdata;
            CSR_SHARED_TIME:     cfg_ff.shared_time     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   lat_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lat_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

`ifndef SYNTHESIS
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in work");

   a_fire_needs_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !cfg_ff.duration_finite |-> !rsp_data.action_fired)
      else $error("action fired without a finite duration");

   a_fire_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.action_fired |-> (rsp_data.is_stopped != cfg_ff.looped))
      else $error("fired tick has wrong stopped state for its mode");
`endif

endmodule
